// ===== rtl/i2cra_pkg.sv =====
// Shared types and constants for the I2C register access master.
// No dependencies; imported by i2cra_seq and i2c_master_register_access.
package i2cra_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned HalfW    = 10;
  localparam int unsigned CfgDataW = HalfW;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_SPARE = 2'd3
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEV_WR  = 2'd0,
    CFG_DEV_RD  = 2'd1,
    CFG_HALF    = 2'd2,
    CFG_ACK_TO  = 2'd3
  } cfg_idx_e;

  localparam logic [ByteW-1:0] DevWrReset = 8'h01;
  localparam logic [ByteW-1:0] DevRdReset = 8'h02;
  localparam logic [HalfW-1:0] HalfReset  = 10'd10;
  localparam logic [ByteW-1:0] AckToReset = 8'd255;

  typedef struct packed {
    logic [ByteW-1:0] dev_wr;
    logic [ByteW-1:0] dev_rd;
    logic [HalfW-1:0] half;
    logic [ByteW-1:0] ack_to;
  } cfg_t;

  typedef struct packed {
    logic             scl;
    logic             sda;
    logic             busy;
    logic             done;
    logic [ByteW-1:0] rd_data;
    logic             ack_missing;
  } res_t;

endpackage

// ===== rtl/i2cra_seq.sv =====
// Pin sequencer of the I2C register access master: holds the bus state and
// advances it by one tick per accepted word. Depends on i2cra_pkg.
module i2cra_seq (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  i2cra_pkg::cfg_t          cfg_i,
  input  logic [1:0]               req_type_i,
  input  logic [7:0]               reg_addr_i,
  input  logic [7:0]               write_data_i,
  input  logic                     sda_in_i,
  output i2cra_pkg::res_t          res_o
);
  import i2cra_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'd0,
    ST_START_A  = 5'd1,
    ST_START_B  = 5'd2,
    ST_WB_LOW   = 5'd3,
    ST_WB_DATA  = 5'd4,
    ST_WB_HIGH  = 5'd5,
    ST_WB_END1  = 5'd6,
    ST_WB_END2  = 5'd7,
    ST_ACK_HIGH = 5'd8,
    ST_ACK_WAIT = 5'd9,
    ST_ACK_LOW  = 5'd10,
    ST_RB_START = 5'd11,
    ST_RB_HIGH  = 5'd12,
    ST_RB_LOW   = 5'd13,
    ST_RB_TAIL  = 5'd14,
    ST_STOP_A   = 5'd15,
    ST_STOP_B   = 5'd16,
    ST_STOP_C   = 5'd17
  } step_e;

  step_e            step_q, step_d;
  logic [3:0]       bit_q, bit_d;
  logic [ByteW-1:0] shift_q, shift_d;
  logic [HalfW-1:0] phase_q, phase_d;
  logic [ByteW-1:0] wait_q, wait_d;
  logic             is_rd_q, is_rd_d;
  logic [ByteW-1:0] addr_q, addr_d;
  logic [ByteW-1:0] wdata_q, wdata_d;
  logic [ByteW-1:0] rx_q, rx_d;
  logic             scl_q, scl_d;
  logic             sda_q, sda_d;
  logic             nack_q, nack_d;
  logic [1:0]       pos_q, pos_d;
  logic             done_d;
  logic             entered;
  logic [HalfW-1:0] hold;
  logic [HalfW-1:0] phase_inc;
  logic [3:0]       bit_inc;

  assign hold      = (cfg_i.half == '0) ? HalfW'(1) : cfg_i.half;
  assign phase_inc = phase_q + HalfW'(1);
  assign bit_inc   = bit_q + 4'd1;

  always_comb begin
    step_d  = step_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    phase_d = phase_q;
    wait_d  = wait_q;
    is_rd_d = is_rd_q;
    addr_d  = addr_q;
    wdata_d = wdata_q;
    rx_d    = rx_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    nack_d  = nack_q;
    pos_d   = pos_q;
    done_d  = 1'b0;
    entered = 1'b0;

    if (step_q == ST_IDLE) begin
      if (req_type_i == REQ_WRITE || req_type_i == REQ_READ) begin
        is_rd_d = (req_type_i == REQ_READ);
        addr_d  = reg_addr_i;
        wdata_d = write_data_i;
        nack_d  = 1'b0;
        pos_d   = 2'd0;
        bit_d   = 4'd0;
        step_d  = ST_START_A;
        entered = 1'b1;
      end
    end else if (step_q == ST_ACK_WAIT) begin
      if (!sda_in_i) begin
        step_d  = ST_ACK_LOW;
        entered = 1'b1;
      end else if (wait_q >= cfg_i.ack_to) begin
        nack_d  = 1'b1;
        step_d  = ST_ACK_LOW;
        entered = 1'b1;
      end else begin
        wait_d = wait_q + ByteW'(1);
      end
    end else begin
      phase_d = phase_inc;
      if (phase_inc >= hold) begin
        entered = 1'b1;
        case (step_q)
          ST_START_A: step_d = ST_START_B;
          ST_START_B: begin
            if (pos_q == 2'd0) begin
              shift_d = cfg_i.dev_wr;
            end else begin
              shift_d = cfg_i.dev_rd;
              pos_d   = 2'd2;
            end
            bit_d  = 4'd0;
            step_d = ST_WB_LOW;
          end
          ST_WB_LOW:  step_d = ST_WB_DATA;
          ST_WB_DATA: step_d = ST_WB_HIGH;
          ST_WB_HIGH: begin
            shift_d = {shift_q[ByteW-2:0], 1'b0};
            bit_d   = bit_inc;
            step_d  = (bit_inc >= 4'd8) ? ST_WB_END1 : ST_WB_LOW;
          end
          ST_WB_END1:  step_d = ST_WB_END2;
          ST_WB_END2:  step_d = ST_ACK_HIGH;
          ST_ACK_HIGH: step_d = ST_ACK_WAIT;
          ST_ACK_LOW: begin
            if (pos_q == 2'd0) begin
              shift_d = addr_q;
              pos_d   = 2'd1;
              bit_d   = 4'd0;
              step_d  = ST_WB_LOW;
            end else if (pos_q == 2'd1) begin
              if (is_rd_q) begin
                step_d = ST_START_A;  // repeated start
              end else begin
                shift_d = wdata_q;
                pos_d   = 2'd2;
                bit_d   = 4'd0;
                step_d  = ST_WB_LOW;
              end
            end else begin
              step_d = is_rd_q ? ST_RB_START : ST_STOP_A;
            end
          end
          ST_RB_START: begin
            bit_d  = 4'd0;
            step_d = ST_RB_HIGH;
          end
          ST_RB_HIGH: begin
            shift_d = {shift_q[ByteW-2:0], sda_in_i};
            step_d  = ST_RB_LOW;
          end
          ST_RB_LOW: begin
            bit_d = bit_inc;
            if (bit_inc >= 4'd8) begin
              rx_d   = shift_q;
              step_d = ST_RB_TAIL;
            end else begin
              step_d = ST_RB_HIGH;
            end
          end
          ST_RB_TAIL: step_d = ST_STOP_A;
          ST_STOP_A:  step_d = ST_STOP_B;
          ST_STOP_B:  step_d = ST_STOP_C;
          ST_STOP_C: begin
            entered = 1'b0;
            step_d  = ST_IDLE;
            phase_d = '0;
            done_d  = 1'b1;
          end
          default: begin
            entered = 1'b0;
            step_d  = ST_IDLE;
            phase_d = '0;
          end
        endcase
      end
    end

    // pin levels set on entry to each phase
    if (entered) begin
      phase_d = '0;
      case (step_d)
        ST_START_A: begin
          scl_d = 1'b1;
          sda_d = 1'b1;
        end
        ST_START_B:  sda_d  = 1'b0;
        ST_WB_LOW:   scl_d  = 1'b0;
        ST_WB_DATA:  sda_d  = shift_d[ByteW-1];
        ST_WB_HIGH:  scl_d  = 1'b1;
        ST_WB_END1:  scl_d  = 1'b0;
        ST_WB_END2:  sda_d  = 1'b1;
        ST_ACK_HIGH: scl_d  = 1'b1;
        ST_ACK_WAIT: wait_d = '0;
        ST_ACK_LOW:  scl_d  = 1'b0;
        ST_RB_START: scl_d  = 1'b0;
        ST_RB_HIGH: begin
          scl_d = 1'b1;
          sda_d = 1'b1;
        end
        ST_RB_LOW:   scl_d  = 1'b0;
        ST_STOP_A:   sda_d  = 1'b0;
        ST_STOP_B:   scl_d  = 1'b1;
        ST_STOP_C:   sda_d  = 1'b1;
        default: begin
          scl_d = scl_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= ST_IDLE;
      bit_q   <= '0;
      shift_q <= '0;
      phase_q <= '0;
      wait_q  <= '0;
      is_rd_q <= 1'b0;
      addr_q  <= '0;
      wdata_q <= '0;
      rx_q    <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      nack_q  <= 1'b0;
      pos_q   <= '0;
    end else if (adv_i) begin
      step_q  <= step_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      phase_q <= phase_d;
      wait_q  <= wait_d;
      is_rd_q <= is_rd_d;
      addr_q  <= addr_d;
      wdata_q <= wdata_d;
      rx_q    <= rx_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      nack_q  <= nack_d;
      pos_q   <= pos_d;
    end
  end

  assign res_o.scl         = scl_d;
  assign res_o.sda         = sda_d;
  assign res_o.busy        = (step_d != ST_IDLE);
  assign res_o.done        = done_d;
  assign res_o.rd_data     = rx_d;
  assign res_o.ack_missing = nack_d;

`ifndef SYNTHESIS
  a_done_from_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_d |-> (step_q == ST_STOP_C && step_d == ST_IDLE))
    else $error("done without final stop phase");
  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q <= 4'd8)
    else $error("bit count beyond a byte");
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q != 2'd3)
    else $error("byte position out of range");
  a_idle_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == ST_IDLE) |-> (scl_q && sda_q))
    else $error("bus not released while idle");
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && step_q != ST_IDLE && step_q != ST_ACK_WAIT) |=> (phase_q <= hold))
    else $error("phase counter overran hold time");
`endif

endmodule

// ===== rtl/i2c_master_register_access.sv =====
// Top level of the I2C register access master: configuration registers,
// input/output handshake and result register. Depends on i2cra_pkg, i2cra_seq.
//
//  channel  | direction | handshake               | word
//  ---------+-----------+-------------------------+---------------------------------
//  in       | input     | in_valid_i / in_stall_o | req_type, reg_addr, write_data, sda_in
//  out      | output    | out_valid_o/out_stall_i | scl/sda levels, busy, done, data, ack
//  cfg      | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// One input word per cycle while in_stall_o is low; each word is one bus tick and yields
// one result word in the next cycle, from the result register behind the sequencer.
// in_stall_o is high only while the result register is full and stalled.
// Reset (async, active low) clears the sequencer to idle with both lines
// released, and loads the configuration reset values.
module i2c_master_register_access (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [i2cra_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [i2cra_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     req_type_i,
  input  logic [7:0]                     reg_addr_i,
  input  logic [7:0]                     write_data_i,
  input  logic                           sda_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           scl_out_o,
  output logic                           sda_out_o,
  output logic                           busy_res_o,
  output logic                           done_res_o,
  output logic [7:0]                     read_data_o,
  output logic                           ack_missing_o
);
  import i2cra_pkg::*;

  cfg_t cfg_q;
  res_t res;
  res_t res_q;
  logic out_valid_q;
  logic accept;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_wr <= DevWrReset;
      cfg_q.dev_rd <= DevRdReset;
      cfg_q.half   <= HalfReset;
      cfg_q.ack_to <= AckToReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DEV_WR: cfg_q.dev_wr <= cfg_data_i[ByteW-1:0];
        CFG_DEV_RD: cfg_q.dev_rd <= cfg_data_i[ByteW-1:0];
        CFG_HALF:   cfg_q.half   <= cfg_data_i[HalfW-1:0];
        CFG_ACK_TO: cfg_q.ack_to <= cfg_data_i[ByteW-1:0];
        default:    cfg_q.half   <= cfg_q.half;
      endcase
    end
  end

  i2cra_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (accept),
    .cfg_i        (cfg_q),
    .req_type_i   (req_type_i),
    .reg_addr_i   (reg_addr_i),
    .write_data_i (write_data_i),
    .sda_in_i     (sda_in_i),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign scl_out_o     = res_q.scl;
  assign sda_out_o     = res_q.sda;
  assign busy_res_o    = res_q.busy;
  assign done_res_o    = res_q.done;
  assign read_data_o   = res_q.rd_data;
  assign ack_missing_o = res_q.ack_missing;

endmodule

// ===== tb/i2cra_bus_checker.sv =====
// Checker for the I2C register access master: shadows the configuration,
// predicts the bus levels for every accepted input word and compares results.
// Depends on i2cra_pkg.
`timescale 1ns / 1ps

module i2cra_bus_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [i2cra_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [i2cra_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [1:0]                     req_type_i,
  input  logic [7:0]                     reg_addr_i,
  input  logic [7:0]                     write_data_i,
  input  logic                           sda_in_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic                           scl_i,
  input  logic                           sda_i,
  input  logic                           busy_i,
  input  logic                           done_i,
  input  logic [7:0]                     read_data_i,
  input  logic                           ack_missing_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output logic                           seq_busy_o
);
  import i2cra_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_START_HI,
    PH_START_LO,
    PH_BIT_LOW,
    PH_BIT_DATA,
    PH_BIT_HIGH,
    PH_BYTE_END_SCL,
    PH_BYTE_END_SDA,
    PH_ACK_HIGH,
    PH_ACK_WAIT,
    PH_ACK_LOW,
    PH_RD_START,
    PH_RD_HIGH,
    PH_RD_LOW,
    PH_RD_TAIL,
    PH_STOP_SDA,
    PH_STOP_SCL,
    PH_STOP_REL
  } bus_phase_e;

  // which byte of the transfer is on the wire
  localparam logic [1:0] POS_DEV  = 2'd0;
  localparam logic [1:0] POS_REG  = 2'd1;
  localparam logic [1:0] POS_LAST = 2'd2;

  cfg_t        shadow_cfg;
  bus_phase_e  bus_phase;
  logic [3:0]  bits_done;
  logic [7:0]  shifter;
  logic [9:0]  hold_cnt;
  logic [7:0]  ack_wait;
  logic        is_read;
  logic [7:0]  lat_addr;
  logic [7:0]  lat_data;
  logic [7:0]  rx_byte;
  logic        scl_lvl;
  logic        sda_lvl;
  logic        nack;
  logic [1:0]  byte_pos;
  logic        done_pulse;
  res_t        bus_levels_q[$];
  res_t        head_word;
  int          mismatches;

  function automatic void enter_phase(bus_phase_e p);
    bus_phase = p;
    hold_cnt  = '0;
    case (p)
      PH_START_HI: begin
        scl_lvl = 1'b1;
        sda_lvl = 1'b1;
      end
      PH_START_LO:     sda_lvl = 1'b0;
      PH_BIT_LOW:      scl_lvl = 1'b0;
      PH_BIT_DATA:     sda_lvl = shifter[7];
      PH_BIT_HIGH:     scl_lvl = 1'b1;
      PH_BYTE_END_SCL: scl_lvl = 1'b0;
      PH_BYTE_END_SDA: sda_lvl = 1'b1;
      PH_ACK_HIGH:     scl_lvl = 1'b1;
      PH_ACK_WAIT:     ack_wait = '0;
      PH_ACK_LOW:      scl_lvl = 1'b0;
      PH_RD_START:     scl_lvl = 1'b0;
      PH_RD_HIGH: begin
        scl_lvl = 1'b1;
        sda_lvl = 1'b1;
      end
      PH_RD_LOW:       scl_lvl = 1'b0;
      PH_STOP_SDA:     sda_lvl = 1'b0;
      PH_STOP_SCL:     scl_lvl = 1'b1;
      PH_STOP_REL:     sda_lvl = 1'b1;
      default: ;
    endcase
  endfunction

  function automatic void load_byte(logic [7:0] b, logic [1:0] pos);
    shifter   = b;
    byte_pos  = pos;
    bits_done = '0;
    enter_phase(PH_BIT_LOW);
  endfunction

  function automatic void end_phase(logic sda);
    case (bus_phase)
      PH_START_HI: enter_phase(PH_START_LO);
      PH_START_LO: begin
        // device byte is taken from the register now, not at request time
        if (byte_pos == POS_DEV) load_byte(shadow_cfg.dev_wr, POS_DEV);
        else load_byte(shadow_cfg.dev_rd, POS_LAST);
      end
      PH_BIT_LOW:  enter_phase(PH_BIT_DATA);
      PH_BIT_DATA: enter_phase(PH_BIT_HIGH);
      PH_BIT_HIGH: begin
        shifter   = shifter << 1;
        bits_done = bits_done + 4'd1;
        if (bits_done >= 4'd8) enter_phase(PH_BYTE_END_SCL);
        else enter_phase(PH_BIT_LOW);
      end
      PH_BYTE_END_SCL: enter_phase(PH_BYTE_END_SDA);
      PH_BYTE_END_SDA: enter_phase(PH_ACK_HIGH);
      PH_ACK_HIGH:     enter_phase(PH_ACK_WAIT);
      PH_ACK_LOW: begin
        if (byte_pos == POS_DEV) begin
          load_byte(lat_addr, POS_REG);
        end else if (byte_pos == POS_REG) begin
          // reads go back through a repeated start
          if (is_read) enter_phase(PH_START_HI);
          else load_byte(lat_data, POS_LAST);
        end else if (is_read) begin
          enter_phase(PH_RD_START);
        end else begin
          enter_phase(PH_STOP_SDA);
        end
      end
      PH_RD_START: begin
        bits_done = '0;
        enter_phase(PH_RD_HIGH);
      end
      PH_RD_HIGH: begin
        shifter = {shifter[6:0], sda};
        enter_phase(PH_RD_LOW);
      end
      PH_RD_LOW: begin
        bits_done = bits_done + 4'd1;
        if (bits_done >= 4'd8) begin
          rx_byte = shifter;
          enter_phase(PH_RD_TAIL);
        end else begin
          enter_phase(PH_RD_HIGH);
        end
      end
      PH_RD_TAIL:  enter_phase(PH_STOP_SDA);
      PH_STOP_SDA: enter_phase(PH_STOP_SCL);
      PH_STOP_SCL: enter_phase(PH_STOP_REL);
      PH_STOP_REL: begin
        bus_phase  = PH_IDLE;
        hold_cnt   = '0;
        done_pulse = 1'b1;
      end
      default: begin
        bus_phase = PH_IDLE;
        hold_cnt  = '0;
      end
    endcase
  endfunction

  // one bus tick: advance the sequencer and return the levels it shows
  function automatic res_t next_bus_levels(req_e req, logic [7:0] addr, logic [7:0] data,
                                           logic sda);
    logic [9:0] hold;
    res_t       r;
    hold       = (shadow_cfg.half == '0) ? 10'd1 : shadow_cfg.half;
    done_pulse = 1'b0;
    if (bus_phase == PH_IDLE) begin
      if (req == REQ_WRITE || req == REQ_READ) begin
        is_read   = (req == REQ_READ);
        lat_addr  = addr;
        lat_data  = data;
        nack      = 1'b0;
        byte_pos  = POS_DEV;
        bits_done = '0;
        enter_phase(PH_START_HI);
      end
    end else if (bus_phase == PH_ACK_WAIT) begin
      if (!sda) begin
        enter_phase(PH_ACK_LOW);
      end else if (ack_wait >= shadow_cfg.ack_to) begin
        nack = 1'b1;
        enter_phase(PH_ACK_LOW);
      end else begin
        ack_wait = ack_wait + 8'd1;
      end
    end else begin
      hold_cnt = hold_cnt + 10'd1;
      if (hold_cnt >= hold) end_phase(sda);
    end
    r.scl         = scl_lvl;
    r.sda         = sda_lvl;
    r.busy        = (bus_phase != PH_IDLE);
    r.done        = done_pulse;
    r.rd_data     = rx_byte;
    r.ack_missing = nack;
    return r;
  endfunction

  function automatic void check_field(string what, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want_v, got_v);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_cfg.dev_wr = DevWrReset;
      shadow_cfg.dev_rd = DevRdReset;
      shadow_cfg.half   = HalfReset;
      shadow_cfg.ack_to = AckToReset;
      bus_phase  = PH_IDLE;
      bits_done  = '0;
      shifter    = '0;
      hold_cnt   = '0;
      ack_wait   = '0;
      is_read    = 1'b0;
      lat_addr   = '0;
      lat_data   = '0;
      rx_byte    = '0;
      scl_lvl    = 1'b1;
      sda_lvl    = 1'b1;
      nack       = 1'b0;
      byte_pos   = POS_DEV;
      done_pulse = 1'b0;
      bus_levels_q.delete();
      pending_o  = 0;
      seq_busy_o = 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEV_WR: shadow_cfg.dev_wr = cfg_data_i[ByteW-1:0];
          CFG_DEV_RD: shadow_cfg.dev_rd = cfg_data_i[ByteW-1:0];
          CFG_HALF:   shadow_cfg.half   = cfg_data_i[HalfW-1:0];
          CFG_ACK_TO: shadow_cfg.ack_to = cfg_data_i[ByteW-1:0];
          default: ;
        endcase
      end
      // compare before queueing this edge's input word: the result is older
      if (out_valid_i && !out_stall_i) begin
        if (bus_levels_q.size() == 0) begin
          mismatches++;
          $display("%0t: result word with nothing expected", $time);
        end else begin
          head_word = bus_levels_q.pop_front();
          check_field("scl", 8'(head_word.scl), 8'(scl_i));
          check_field("sda", 8'(head_word.sda), 8'(sda_i));
          check_field("busy", 8'(head_word.busy), 8'(busy_i));
          check_field("done", 8'(head_word.done), 8'(done_i));
          check_field("read_data", head_word.rd_data, read_data_i);
          check_field("ack_missing", 8'(head_word.ack_missing), 8'(ack_missing_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        bus_levels_q.push_back(next_bus_levels(req_e'(req_type_i), reg_addr_i,
                                               write_data_i, sda_in_i));
      end
      pending_o  = bus_levels_q.size();
      seq_busy_o = (bus_phase != PH_IDLE);
    end
  end

  assign fail_count_o = mismatches;

endmodule

// ===== tb/tb_i2c_master_register_access.sv =====
// Testbench top for the I2C register access master: clock, reset, stimulus
// on the input, result and configuration ports, and the final verdict.
// Depends on i2cra_pkg, i2c_master_register_access and i2cra_bus_checker.
`timescale 1ns / 1ps

module tb_i2c_master_register_access;
  import i2cra_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  cfg_idx_e            cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_valid;
  logic                in_stall;
  req_e                req_type;
  logic [7:0]          reg_addr;
  logic [7:0]          write_data;
  logic                sda_in;
  logic                out_valid;
  logic                out_stall;
  logic                scl_out;
  logic                sda_out;
  logic                busy_res;
  logic                done_res;
  logic [7:0]          read_data;
  logic                ack_missing;

  int   fail_count;
  int   words_pending;
  logic seq_busy;

  int   sda_low_pct;
  bit   tx_idle;
  logic rx_idle;
  logic hold_off_req;

  i2c_master_register_access dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .req_type_i    (req_type),
    .reg_addr_i    (reg_addr),
    .write_data_i  (write_data),
    .sda_in_i      (sda_in),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .scl_out_o     (scl_out),
    .sda_out_o     (sda_out),
    .busy_res_o    (busy_res),
    .done_res_o    (done_res),
    .read_data_o   (read_data),
    .ack_missing_o (ack_missing)
  );

  i2cra_bus_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .req_type_i    (req_type),
    .reg_addr_i    (reg_addr),
    .write_data_i  (write_data),
    .sda_in_i      (sda_in),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .scl_i         (scl_out),
    .sda_i         (sda_out),
    .busy_i        (busy_res),
    .done_i        (done_res),
    .read_data_i   (read_data),
    .ack_missing_i (ack_missing),
    .fail_count_o  (fail_count),
    .pending_o     (words_pending),
    .seq_busy_o    (seq_busy)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // All tasks below start and end on a falling edge.
  task automatic push_word(req_e req, logic [7:0] addr, logic [7:0] data);
    if (tx_idle && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= req;
    reg_addr   <= addr;
    write_data <= data;
    sda_in     <= ($urandom_range(0, 99) < sda_low_pct) ? 1'b0 : 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic clock_ticks(int n);
    repeat (n) push_word(REQ_TICK, 8'($urandom), 8'($urandom));
  endtask

  task automatic finish_transfer();
    while (seq_busy) push_word(REQ_TICK, 8'($urandom), 8'($urandom));
  endtask

  // hold the sender until every result word is back
  task automatic drain();
    in_valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(logic [7:0] dev_wr, logic [7:0] dev_rd, logic [9:0] half,
                            logic [7:0] ack_to);
    write_reg(CFG_DEV_WR, CfgDataW'(dev_wr));
    write_reg(CFG_DEV_RD, CfgDataW'(dev_rd));
    write_reg(CFG_HALF, half);
    write_reg(CFG_ACK_TO, CfgDataW'(ack_to));
  endtask

  task automatic random_words(int n);
    int   pick;
    req_e req;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) req = REQ_TICK;
      else if (pick < 82) req = REQ_WRITE;
      else if (pick < 94) req = REQ_READ;
      else req = REQ_SPARE;
      push_word(req, 8'($urandom), 8'($urandom));
    end
  endtask

  // result side: random stall bursts, or one long hold-off on request
  initial begin
    bit held_off;
    held_off  = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !held_off) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (60) @(negedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_DEV_WR;
    cfg_data     = '0;
    in_valid     = 1'b0;
    req_type     = REQ_TICK;
    reg_addr     = '0;
    write_data   = '0;
    sda_in       = 1'b1;
    sda_low_pct  = 50;
    tx_idle      = 1'b1;
    rx_idle      = 1'b1;
    hold_off_req = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset configuration; spare request code at idle acts as a plain tick
    push_word(REQ_SPARE, 8'hFF, 8'hFF);
    push_word(REQ_TICK, 8'h00, 8'h00);
    push_word(REQ_READ, 8'hFF, 8'h00);
    // requests while busy are dropped
    push_word(REQ_WRITE, 8'h00, 8'hFF);
    push_word(REQ_SPARE, 8'h55, 8'hAA);
    clock_ticks(60);

    // mid-transfer change: repeated start picks up the new read byte,
    // zero half phase, SDA stuck high so each ack slot runs to the full timeout
    drain();
    set_config(8'hFF, 8'h00, 10'd0, 8'd16);
    sda_low_pct = 0;
    finish_transfer();
    sda_low_pct = 50;
    push_word(REQ_WRITE, 8'h00, 8'hFF);
    finish_transfer();

    // zero timeout: a high SDA fails the slot at once; then all-low SDA
    drain();
    set_config(8'h00, 8'hFF, 10'd1, 8'd0);
    sda_low_pct = 0;
    push_word(REQ_READ, 8'h3C, 8'hC3);
    finish_transfer();
    sda_low_pct = 100;
    push_word(REQ_READ, 8'hC3, 8'h3C);
    finish_transfer();

    // long half phase for one full phase count, then speed up to finish
    drain();
    set_config(8'hA5, 8'h5A, 10'd40, 8'd1);
    sda_low_pct = 50;
    push_word(REQ_WRITE, 8'h81, 8'h7E);
    clock_ticks(50);
    drain();
    write_reg(CFG_HALF, 10'd1);
    finish_transfer();

    // random traffic; starts with a long hold-off on the result side
    drain();
    set_config(8'($urandom), 8'($urandom), 10'd1, 8'($urandom_range(1, 20)));
    sda_low_pct = 10;
    hold_off_req <= 1'b1;
    random_words(65);

    drain();
    set_config(8'($urandom), 8'($urandom), 10'd0, 8'd0);
    sda_low_pct = 50;
    random_words(65);

    drain();
    set_config(8'($urandom), 8'($urandom), 10'd2, 8'd255);
    random_words(65);

    // last stretch without idling on either side
    drain();
    set_config(8'($urandom), 8'($urandom), 10'd1, 8'd3);
    sda_low_pct = 30;
    tx_idle = 1'b0;
    rx_idle <= 1'b0;
    random_words(65);

    drain();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
